// ===== rtl/cclru_pkg.sv =====
package cclru_pkg;

  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned STAMP_W        = 32;
  localparam int unsigned CFG_W          = 4;
  localparam int unsigned SLOT_OUT_W     = 3;
  localparam int unsigned CHUNK_OUT_W    = 17;
  localparam int unsigned SLOTS_DEF      = 8;
  localparam int unsigned CHUNK_BITS_DEF = 15;
  localparam int unsigned ACTIVE_MIN     = 2;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

  typedef struct packed {
    logic valid;
    logic hit;
    logic have_empty;
    logic have_best;
    logic victim_valid;
  } ctl_t;

  typedef struct packed {
    logic en;
    logic install;
  } wr_t;

endpackage

// ===== rtl/cclru_cell.sv =====
module cclru_cell #(
  parameter int unsigned TAG_W  = 17,
  parameter int unsigned SLOT_W = 3,
  parameter int unsigned INDEX  = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  cclru_pkg::ctl_t               ctl_i,
  input  logic [TAG_W-1:0]              chunk_i,
  input  logic [cclru_pkg::STAMP_W-1:0] best_i,
  input  logic [SLOT_W-1:0]             victim_i,
  input  logic [TAG_W-1:0]              vtag_i,
  output cclru_pkg::ctl_t               ctl_o,
  output logic [TAG_W-1:0]              chunk_o,
  output logic [cclru_pkg::STAMP_W-1:0] best_o,
  output logic [SLOT_W-1:0]             victim_o,
  output logic [TAG_W-1:0]              vtag_o,
  input  cclru_pkg::wr_t                wr_i,
  input  logic [SLOT_W-1:0]             wr_idx_i,
  input  logic [TAG_W-1:0]              wr_tag_i,
  input  logic [cclru_pkg::STAMP_W-1:0] wr_stamp_i
);

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(INDEX);

  logic                          valid_q;
  logic [TAG_W-1:0]              tag_q;
  logic [cclru_pkg::STAMP_W-1:0] stamp_q;

  cclru_pkg::ctl_t               ctl_d, ctl_q;
  logic [TAG_W-1:0]              chunk_q;
  logic [cclru_pkg::STAMP_W-1:0] best_d, best_q;
  logic [SLOT_W-1:0]             victim_d, victim_q;
  logic [TAG_W-1:0]              vtag_d, vtag_q;
  logic                          wr_me;

  assign wr_me = wr_i.en && (wr_idx_i == MY_IDX);

  always_comb begin
    ctl_d    = ctl_i;
    best_d   = best_i;
    victim_d = victim_i;
    vtag_d   = vtag_i;
    if (ctl_i.valid && en_i && !ctl_i.hit) begin
      if (valid_q && (tag_q == chunk_i)) begin
        ctl_d.hit = 1'b1;
        victim_d  = MY_IDX;
      end else if (!valid_q) begin
        if (!ctl_i.have_empty) begin
          ctl_d.have_empty   = 1'b1;
          ctl_d.victim_valid = 1'b0;
          victim_d           = MY_IDX;
          vtag_d             = '0;
        end
      end else if (!ctl_i.have_empty) begin
        if (!ctl_i.have_best || (stamp_q < best_i)) begin
          ctl_d.have_best    = 1'b1;
          ctl_d.victim_valid = 1'b1;
          best_d             = stamp_q;
          victim_d           = MY_IDX;
          vtag_d             = tag_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tag_q   <= '0;
      stamp_q <= '0;
    end else if (wr_me) begin
      stamp_q <= wr_stamp_i;
      if (wr_i.install) begin
        valid_q <= 1'b1;
        tag_q   <= wr_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chunk_q  <= chunk_i;
    best_q   <= best_d;
    victim_q <= victim_d;
    vtag_q   <= vtag_d;
  end

  assign ctl_o    = ctl_q;
  assign chunk_o  = chunk_q;
  assign best_o   = best_q;
  assign victim_o = victim_q;
  assign vtag_o   = vtag_q;

endmodule

// ===== rtl/chunk_cache_lru_lookup.sv =====
// Channel   Direction  Handshake              Payload
// request   in         start && !busy         address_i
// result    out        done_o (one cycle)     slot_o, hit_o, fill_chunk_o,
//                                             evict_valid_o, evict_chunk_o
// config    in         cfg_we_i               cfg_wdata_i (active slots)
//
// A request walks the chain of slot cells, one cell per cycle, then commits the
// tag/stamp update and registers the result.
// done_o pulses in the cycle after the commit; busy drops in that same cycle.
// Reset empties all slots, clears the access counter and sets active slots to 8.
// The receiver cannot stall; each result shows for exactly one cycle.
module chunk_cache_lru_lookup #(
  parameter int unsigned SLOTS      = cclru_pkg::SLOTS_DEF,
  parameter int unsigned CHUNK_BITS = cclru_pkg::CHUNK_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [cclru_pkg::ADDR_W-1:0]      address_i,
  output logic                              done_o,
  output logic [cclru_pkg::SLOT_OUT_W-1:0]  slot_o,
  output logic                              hit_o,
  output logic [cclru_pkg::CHUNK_OUT_W-1:0] fill_chunk_o,
  output logic                              evict_valid_o,
  output logic [cclru_pkg::CHUNK_OUT_W-1:0] evict_chunk_o,
  input  logic                              cfg_we_i,
  input  logic [cclru_pkg::CFG_W-1:0]       cfg_wdata_i
);

  localparam int unsigned TAG_W  = cclru_pkg::ADDR_W - CHUNK_BITS;
  localparam int unsigned SLOT_W = $clog2(SLOTS);

  logic [cclru_pkg::CFG_W-1:0]   active_q;
  logic [cclru_pkg::STAMP_W-1:0] clock_q, clock_d;
  logic                          busy_q;
  logic                          accept;
  logic                          commit;

  cclru_pkg::ctl_t               ctl    [SLOTS+1];
  logic [TAG_W-1:0]              chunk  [SLOTS+1];
  logic [cclru_pkg::STAMP_W-1:0] best   [SLOTS+1];
  logic [SLOT_W-1:0]             victim [SLOTS+1];
  logic [TAG_W-1:0]              vtag   [SLOTS+1];
  logic [SLOTS-1:0]              en;

  cclru_pkg::wr_t                wr;
  logic [cclru_pkg::ADDR_W-1:0]  slot_ext, fill_ext, evict_ext;

  logic                              done_q;
  logic [cclru_pkg::SLOT_OUT_W-1:0]  slot_q;
  logic                              hit_q;
  logic [cclru_pkg::CHUNK_OUT_W-1:0] fill_q;
  logic                              evict_valid_q;
  logic [cclru_pkg::CHUNK_OUT_W-1:0] evict_q;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  assign ctl[0]    = '{valid: accept, hit: 1'b0, have_empty: 1'b0,
                       have_best: 1'b0, victim_valid: 1'b0};
  assign chunk[0]  = address_i[cclru_pkg::ADDR_W-1:CHUNK_BITS];
  assign best[0]   = '0;
  assign victim[0] = '0;
  assign vtag[0]   = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    assign en[g] = (g < cclru_pkg::ACTIVE_MIN) ||
                   (32'(g) < 32'(active_q));

    cclru_cell #(
      .TAG_W (TAG_W),
      .SLOT_W(SLOT_W),
      .INDEX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en[g]),
      .ctl_i     (ctl[g]),
      .chunk_i   (chunk[g]),
      .best_i    (best[g]),
      .victim_i  (victim[g]),
      .vtag_i    (vtag[g]),
      .ctl_o     (ctl[g+1]),
      .chunk_o   (chunk[g+1]),
      .best_o    (best[g+1]),
      .victim_o  (victim[g+1]),
      .vtag_o    (vtag[g+1]),
      .wr_i      (wr),
      .wr_idx_i  (victim[SLOTS]),
      .wr_tag_i  (chunk[SLOTS]),
      .wr_stamp_i(clock_d)
    );
  end

  assign commit     = ctl[SLOTS].valid;
  assign clock_d    = clock_q + 1'b1;
  assign wr.en      = commit;
  assign wr.install = !ctl[SLOTS].hit;

  assign slot_ext  = 32'(victim[SLOTS]);
  assign fill_ext  = 32'(chunk[SLOTS]);
  assign evict_ext = 32'(vtag[SLOTS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= cclru_pkg::ACTIVE_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      clock_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= commit;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (commit) begin
        busy_q <= 1'b0;
      end
      if (commit) begin
        clock_q <= clock_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      slot_q <= slot_ext[cclru_pkg::SLOT_OUT_W-1:0];
      hit_q  <= ctl[SLOTS].hit;
      if (ctl[SLOTS].hit) begin
        fill_q        <= '0;
        evict_valid_q <= 1'b0;
        evict_q       <= '0;
      end else begin
        fill_q        <= fill_ext[cclru_pkg::CHUNK_OUT_W-1:0];
        evict_valid_q <= ctl[SLOTS].victim_valid;
        evict_q       <= evict_ext[cclru_pkg::CHUNK_OUT_W-1:0];
      end
    end
  end

  assign done_o        = done_q;
  assign slot_o        = slot_q;
  assign hit_o         = hit_q;
  assign fill_chunk_o  = fill_q;
  assign evict_valid_o = evict_valid_q;
  assign evict_chunk_o = evict_q;

endmodule

// ===== bench/tb_chunk_cache_lru_lookup.sv =====
`timescale 1ns / 100ps

module tb_chunk_cache_lru_lookup;
  import cclru_pkg::*;

  localparam int unsigned SLOTS        = SLOTS_DEF;
  localparam int unsigned CHUNK_W      = ADDR_W - CHUNK_BITS_DEF;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = SLOTS + 4;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_ITEMS  = 132;
  localparam int unsigned POOL_MAX     = 12;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0]  slot;
    logic                   hit;
    logic [CHUNK_OUT_W-1:0] fill_chunk;
    logic                   evict_valid;
    logic [CHUNK_OUT_W-1:0] evict_chunk;
  } lookup_result_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   start       = 1'b0;
  logic                   busy;
  logic [ADDR_W-1:0]      address_i   = '0;
  logic                   done_o;
  logic [SLOT_OUT_W-1:0]  slot_o;
  logic                   hit_o;
  logic [CHUNK_OUT_W-1:0] fill_chunk_o;
  logic                   evict_valid_o;
  logic [CHUNK_OUT_W-1:0] evict_chunk_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;

  // lookup state mirror
  logic [CHUNK_W-1:0] cached_tag   [SLOTS];
  logic               cached_valid [SLOTS];
  logic [STAMP_W-1:0] cached_stamp [SLOTS];
  logic [STAMP_W-1:0] access_count;
  logic [CFG_W-1:0]   active_setting;

  lookup_result_t expected_lookups [$];
  lookup_result_t observed;
  lookup_result_t wanted;

  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned request_count = 0;
  int unsigned hit_count     = 0;
  int unsigned evict_count   = 0;
  int unsigned config_writes = 0;

  logic [CHUNK_W-1:0] fill_tags [SLOTS];

  chunk_cache_lru_lookup uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .address_i     (address_i),
    .done_o        (done_o),
    .slot_o        (slot_o),
    .hit_o         (hit_o),
    .fill_chunk_o  (fill_chunk_o),
    .evict_valid_o (evict_valid_o),
    .evict_chunk_o (evict_chunk_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_lookups.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      observed = {slot_o, hit_o, fill_chunk_o, evict_valid_o, evict_chunk_o};
      if (expected_lookups.size() == 0) begin
        flag_error($sformatf("unexpected result slot=%0d hit=%0b", slot_o, hit_o));
      end else begin
        wanted = expected_lookups.pop_front();
        if (observed.slot !== wanted.slot || observed.hit !== wanted.hit ||
            observed.fill_chunk !== wanted.fill_chunk ||
            observed.evict_valid !== wanted.evict_valid ||
            observed.evict_chunk !== wanted.evict_chunk) begin
          flag_error($sformatf({"mismatch: expected slot=%0d hit=%0b fill=%h evict=%0b/%h,",
                                " got slot=%0d hit=%0b fill=%h evict=%0b/%h"},
                               wanted.slot, wanted.hit, wanted.fill_chunk,
                               wanted.evict_valid, wanted.evict_chunk,
                               observed.slot, observed.hit, observed.fill_chunk,
                               observed.evict_valid, observed.evict_chunk));
        end
      end
    end
  end

  function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
    lookup_result_t     r;
    logic [CHUNK_W-1:0] chunk;
    logic [STAMP_W-1:0] oldest;
    int unsigned        n;
    int unsigned        i;
    int unsigned        victim;
    bit                 found_hit;
    bit                 found_empty;
    bit                 found_old;
    chunk       = addr[ADDR_W-1:CHUNK_BITS_DEF];
    n           = active_setting;
    r           = '0;
    victim      = 0;
    oldest      = '0;
    found_hit   = 1'b0;
    found_empty = 1'b0;
    found_old   = 1'b0;
    if (n < ACTIVE_MIN) n = ACTIVE_MIN;
    if (n > SLOTS) n = SLOTS;
    for (i = 0; i < n; i++) begin
      if (!found_hit && cached_valid[i] && cached_tag[i] == chunk) begin
        found_hit = 1'b1;
        victim    = i;
      end
    end
    if (found_hit) begin
      access_count         = access_count + 1'b1;
      cached_stamp[victim] = access_count;
      r.slot               = SLOT_OUT_W'(victim);
      r.hit                = 1'b1;
      return r;
    end
    for (i = 0; i < n; i++) begin
      if (!cached_valid[i]) begin
        if (!found_empty) begin
          found_empty = 1'b1;
          victim      = i;
        end
      end else if (!found_empty && (!found_old || cached_stamp[i] < oldest)) begin
        found_old = 1'b1;
        oldest    = cached_stamp[i];
        victim    = i;
      end
    end
    r.slot       = SLOT_OUT_W'(victim);
    r.fill_chunk = CHUNK_OUT_W'(chunk);
    if (cached_valid[victim]) begin
      r.evict_valid = 1'b1;
      r.evict_chunk = CHUNK_OUT_W'(cached_tag[victim]);
    end
    cached_tag[victim]   = chunk;
    cached_valid[victim] = 1'b1;
    access_count         = access_count + 1'b1;
    cached_stamp[victim] = access_count;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_in_chunk(input logic [CHUNK_W-1:0] chunk);
    logic [CHUNK_BITS_DEF-1:0] offset;
    offset = CHUNK_BITS_DEF'($urandom);
    return {chunk, offset};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 12);
    return $urandom_range(13, 40);
  endfunction

  task automatic send_request(input logic [ADDR_W-1:0] addr);
    lookup_result_t r;
    start     <= 1'b1;
    address_i <= addr;
    do begin
      @(posedge clk_i);
    end while (busy);
    r = predict_lookup(addr);
    expected_lookups.push_back(r);
    request_count++;
    if (r.hit) hit_count++;
    if (r.evict_valid) evict_count++;
  endtask

  task automatic hold_off(input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_active(input logic [CFG_W-1:0] value);
    drain_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    active_setting = value;
    cfg_we_i <= 1'b0;
    config_writes++;
  endtask

  task automatic test_fill_and_evict();
    int unsigned k;
    send_request(32'h0000_0000);
    send_request(32'h0000_7FFF);
    send_request(32'hFFFF_FFFF);
    send_request(32'hFFFF_8000);
    fill_tags[0] = '0;
    fill_tags[1] = '1;
    for (k = 2; k < SLOTS; k++) begin
      fill_tags[k] = CHUNK_W'(17'h0_1111 * k);
      send_request(addr_in_chunk(fill_tags[k]));
    end
    send_request(32'h0000_1234);
    send_request(addr_in_chunk(17'h0_AAAA));
    send_request(addr_in_chunk(17'h1_5555));
    drain_pipeline();
  endtask

  task automatic test_active_resize();
    write_active(4'd2);
    send_request(addr_in_chunk(fill_tags[4]));
    send_request(addr_in_chunk(17'h0_0000));
    write_active(4'd0);
    send_request(addr_in_chunk(fill_tags[6]));
    write_active(4'd1);
    send_request(addr_in_chunk(fill_tags[4]));
    write_active(4'd15);
    send_request(addr_in_chunk(fill_tags[5]));
    send_request(addr_in_chunk(fill_tags[7]));
    write_active(4'd9);
    send_request(addr_in_chunk(fill_tags[3]));
    drain_pipeline();
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0]   settings [12];
    logic [CHUNK_W-1:0] working_set [POOL_MAX];
    logic [ADDR_W-1:0]  addr;
    int unsigned        phase;
    int unsigned        item;
    int unsigned        pool_size;
    int unsigned        eff;
    int unsigned        j;
    int unsigned        roll;
    bit                 quiet;
    settings = '{4'd2, 4'd8, 4'd5, 4'd3, 4'd15, 4'd0, 4'd7, 4'd1, 4'd9, 4'd4, 4'd6, 4'd8};
    for (phase = 0; phase < 12; phase++) begin
      write_active(settings[phase]);
      eff = settings[phase];
      if (eff < ACTIVE_MIN) eff = ACTIVE_MIN;
      if (eff > SLOTS) eff = SLOTS;
      pool_size = eff + $urandom_range(1, 4);
      for (j = 0; j < POOL_MAX; j++) working_set[j] = CHUNK_W'($urandom);
      if (phase % 3 == 0) begin
        working_set[0] = '0;
        working_set[1] = '1;
      end
      quiet = (phase == 3) || (phase == 9);
      for (item = 0; item < PHASE_ITEMS; item++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          working_set[$urandom_range(0, pool_size - 1)] = CHUNK_W'($urandom);
        end
        if (roll < 85) begin
          addr = addr_in_chunk(working_set[$urandom_range(0, pool_size - 1)]);
        end else begin
          addr = $urandom;
        end
        send_request(addr);
        hold_off(quiet ? 0 : pick_gap());
      end
    end
  endtask

  initial begin
    int unsigned s;
    for (s = 0; s < SLOTS; s++) begin
      cached_tag[s]   = '0;
      cached_valid[s] = 1'b0;
      cached_stamp[s] = '0;
      fill_tags[s]    = '0;
    end
    access_count   = '0;
    active_setting = ACTIVE_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_and_evict();
    test_active_resize();
    test_random_phases();
    drain_pipeline();
    $display("Ran %0d lookups (%0d hits, %0d misses, %0d evictions) over %0d slot-count writes",
             request_count, hit_count, request_count - hit_count, evict_count, config_writes);
    $display("Mismatches or stray results: %0d, results still outstanding: %0d",
             error_count, expected_lookups.size());
    if (error_count == 0 && expected_lookups.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
